// ----- sv/indexed_list_store_assert.svh -----
// assertion macros for the indexed list store checker
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// expression must hold at every rising clock edge out of reset
`define ILS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent must hold whenever the antecedent holds
`define ILS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/ils_pkg.sv -----
// types and codes shared by the indexed list store files
package ils_pkg;

    localparam logic [2:0] FUNC_GET      = 3'd0;
    localparam logic [2:0] FUNC_ADD_HEAD = 3'd1;
    localparam logic [2:0] FUNC_ADD_TAIL = 3'd2;
    localparam logic [2:0] FUNC_ADD_AT   = 3'd3;
    localparam logic [2:0] FUNC_DELETE   = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         position;
        logic signed [31:0] item_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         entry_count;
    } result_t;

endpackage

// ----- sv/indexed_list_store.sv -----
// indexed list store top level: input register, list logic, result register
//
// An ordered list of up to CAPACITY signed 32-bit values. A command is taken
// at every clock edge where start is high; busy never rises, so one command
// can follow another in each cycle. The result of a command shows on result
// with done high for one cycle. The command is first loaded into the input
// register, and the result register is then loaded from it through the
// list decode and count logic. Results come out in command order and the
// receiver cannot stall them, so it must take each one in the cycle done
// is high. Entries come out of reset unwritten; the count resets to zero.
module indexed_list_store #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ils_pkg::cmd_t     cmd,
    output logic              done,
    output ils_pkg::result_t  result
);

    logic              valid_reg;
    ils_pkg::cmd_t     cmd_reg;
    logic              done_reg;
    ils_pkg::result_t  result_reg;
    ils_pkg::result_t  result_next;

    assign busy = 1'b0;

    ils_list #(
        .CAPACITY (CAPACITY)
    ) u_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (valid_reg),
        .cmd      (cmd_reg),
        .result   (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start & ~busy;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cmd_reg <= cmd;
        if (valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- sv/ils_list.sv -----
// list storage, entry count and the per-slot shift logic for one operation
module ils_list #(
    parameter int CAPACITY = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_valid,
    input  ils_pkg::cmd_t   cmd,
    output ils_pkg::result_t result
);

    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW = $clog2(CAPACITY + 1);

    logic signed [31:0] entries_reg  [CAPACITY];
    logic signed [31:0] entries_next [CAPACITY];
    logic [CNTW-1:0]    count_reg;
    logic [CNTW-1:0]    count_next;

    logic [7:0]         pos8;
    logic [7:0]         cnt8;
    logic               full;
    logic               do_ins;
    logic               do_del;
    logic [7:0]         ins_pos;
    logic [1:0]         status;
    logic signed [31:0] read_value;

    assign pos8 = cmd.position;
    assign cnt8 = 8'(count_reg);
    assign full = (count_reg == CNTW'(CAPACITY));

    // decode
    always_comb
    begin
        do_ins     = 1'b0;
        do_del     = 1'b0;
        ins_pos    = 8'd0;
        status     = ils_pkg::ST_DONE;
        read_value = '0;
        case (cmd.func)
            ils_pkg::FUNC_GET:
            begin
                if (pos8 >= cnt8)
                    status = ils_pkg::ST_RANGE;
                else
                    read_value = entries_reg[pos8[IDXW-1:0]];
            end
            ils_pkg::FUNC_ADD_HEAD:
            begin
                if (full)
                    status = ils_pkg::ST_FULL;
                else
                    do_ins = 1'b1;
            end
            ils_pkg::FUNC_ADD_TAIL:
            begin
                ins_pos = cnt8;
                if (full)
                    status = ils_pkg::ST_FULL;
                else
                    do_ins = 1'b1;
            end
            ils_pkg::FUNC_ADD_AT:
            begin
                ins_pos = pos8;
                if (pos8 > cnt8)
                    status = ils_pkg::ST_RANGE;
                else if (full)
                    status = ils_pkg::ST_FULL;
                else
                    do_ins = 1'b1;
            end
            ils_pkg::FUNC_DELETE:
            begin
                if (pos8 >= cnt8)
                    status = ils_pkg::ST_RANGE;
                else
                    do_del = 1'b1;
            end
            default:
            begin
                status = ils_pkg::ST_DONE;
            end
        endcase
        do_ins = do_ins & op_valid;
        do_del = do_del & op_valid;
    end

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CNTW'(1);
        else if (do_del)
            count_next = count_reg - CNTW'(1);
    end

    // every slot picks hold, new value, lower neighbor or upper neighbor (end slots lack one neighbor)
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entries_next[i] = entries_reg[i];
        end
        for (int i = 1; i < CAPACITY; i++)
        begin
            if (do_ins && (8'(i) > ins_pos))
                entries_next[i] = entries_reg[i-1];
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (do_ins && (8'(i) == ins_pos))
                entries_next[i] = cmd.item_value;
        end
        for (int i = 0; i < CAPACITY - 1; i++)
        begin
            if (do_del && (8'(i) >= pos8))
                entries_next[i] = entries_reg[i+1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entries_reg[i] <= entries_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign result.read_value  = read_value;
    assign result.status      = status;
    assign result.entry_count = 7'(count_next);

endmodule

// ----- sv/ils_checker.sv -----
// port-level checker for the indexed list store, bound to the top level
`include "indexed_list_store_assert.svh"

module ils_checker #(
    parameter int CAPACITY = 16
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input ils_pkg::result_t  result
);

    `ILS_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised")
    `ILS_ASSERT_IMPLIES(a_done_has_cmd, clk, rst_n, done, $past(start && !busy, 2), "done without transaction")
    `ILS_ASSERT_IMPLIES(a_full_count, clk, rst_n, done && (result.status == ils_pkg::ST_FULL), result.entry_count == 7'(CAPACITY), "full status below capacity")
    `ILS_ASSERT_IMPLIES(a_fail_zero, clk, rst_n, done && (result.status != ils_pkg::ST_DONE), result.read_value == 0, "nonzero read on failed transaction")
    `ILS_ASSERT_IMPLIES(a_count_bound, clk, rst_n, done, result.entry_count <= 7'(CAPACITY), "count above capacity")

endmodule

bind indexed_list_store ils_checker #(
    .CAPACITY (CAPACITY)
) u_ils_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ----- dv/tb_indexed_list_store.sv -----
// testbench for indexed_list_store: directed and random list commands checked against a shadow list
`timescale 1ns / 100ps

module tb_indexed_list_store;

    localparam int CAPACITY = 16;
    localparam int LIMIT = 200000;

    class list_tracker;
        logic signed [31:0] shadow_slots [CAPACITY];
        int unsigned        shadow_count = 0;
        ils_pkg::result_t   pending_results [$];
        int unsigned        errors = 0;
        int unsigned        n_commands = 0;
        int unsigned        n_results = 0;
        int unsigned        n_full = 0;
        int unsigned        n_range = 0;
        int unsigned        peak_count = 0;

        function void insert_slot(int unsigned at, logic signed [31:0] v);
            for (int unsigned i = shadow_count; i > at; i--)
                shadow_slots[i] = shadow_slots[i - 1];
            shadow_slots[at] = v;
            shadow_count++;
        endfunction

        function void note_command(ils_pkg::cmd_t c);
            ils_pkg::result_t r;
            r = '0;
            r.status = ils_pkg::ST_DONE;
            case (c.func)
                ils_pkg::FUNC_GET:
                begin
                    if (c.position >= shadow_count)
                        r.status = ils_pkg::ST_RANGE;
                    else
                        r.read_value = shadow_slots[c.position];
                end
                ils_pkg::FUNC_ADD_HEAD:
                begin
                    if (shadow_count >= CAPACITY)
                        r.status = ils_pkg::ST_FULL;
                    else
                        insert_slot(0, c.item_value);
                end
                ils_pkg::FUNC_ADD_TAIL:
                begin
                    if (shadow_count >= CAPACITY)
                        r.status = ils_pkg::ST_FULL;
                    else
                        insert_slot(shadow_count, c.item_value);
                end
                ils_pkg::FUNC_ADD_AT:
                begin
                    if (c.position > shadow_count)
                        r.status = ils_pkg::ST_RANGE;
                    else if (shadow_count >= CAPACITY)
                        r.status = ils_pkg::ST_FULL;
                    else
                        insert_slot(c.position, c.item_value);
                end
                ils_pkg::FUNC_DELETE:
                begin
                    if (c.position >= shadow_count)
                        r.status = ils_pkg::ST_RANGE;
                    else
                    begin
                        for (int unsigned i = c.position; i + 1 < shadow_count; i++)
                            shadow_slots[i] = shadow_slots[i + 1];
                        shadow_count--;
                    end
                end
                default:
                begin
                end
            endcase
            r.entry_count = shadow_count[6:0];
            if (r.status == ils_pkg::ST_FULL)
                n_full++;
            if (r.status == ils_pkg::ST_RANGE)
                n_range++;
            if (shadow_count > peak_count)
                peak_count = shadow_count;
            n_commands++;
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(ils_pkg::result_t got);
            ils_pkg::result_t want;
            n_results++;
            if (pending_results.size() == 0)
            begin
                report("result transaction with no command pending");
                return;
            end
            want = pending_results.pop_front();
            if (got.read_value !== want.read_value)
                report($sformatf("read_value got %0d want %0d", got.read_value,
                                 want.read_value));
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.entry_count !== want.entry_count)
                report($sformatf("entry_count got %0d want %0d", got.entry_count,
                                 want.entry_count));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    ils_pkg::cmd_t    cmd;
    logic             done;
    ils_pkg::result_t result;

    list_tracker sb;
    int unsigned n_accepted = 0;
    int unsigned cycles = 0;

    indexed_list_store #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_command(cmd);
                n_accepted++;
            end
            if (done)
                sb.check_result(result);
        end
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(logic [2:0] f, logic [7:0] p, logic signed [31:0] v);
        int unsigned target;
        target = n_accepted + 1;
        cmd.func = f;
        cmd.position = p;
        cmd.item_value = v;
        start = 1'b1;
        while (n_accepted != target)
            @(negedge clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int unsigned items, int unsigned idle_pct);
        int unsigned counted;
        int unsigned roll;
        int unsigned n;
        bit          filling;
        logic [2:0]  f;
        logic [7:0]  p;
        counted = 0;
        filling = (sb.shadow_count < CAPACITY / 2);
        while (counted < items)
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                start = 1'b0;
                @(negedge clk);
            end
            n = sb.shadow_count;
            if (n == CAPACITY && $urandom_range(3) == 0)
                filling = 1'b0;
            if (n == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            roll = $urandom_range(99);
            if (roll < 4)
                f = 3'($urandom_range(7, ils_pkg::FUNC_DELETE + 1));
            else if (roll < 24)
                f = ils_pkg::FUNC_GET;
            else if ((roll < 64) == filling)
            begin
                case ($urandom_range(2))
                    0: f = ils_pkg::FUNC_ADD_HEAD;
                    1: f = ils_pkg::FUNC_ADD_TAIL;
                    default: f = ils_pkg::FUNC_ADD_AT;
                endcase
            end
            else
                f = ils_pkg::FUNC_DELETE;
            // mostly legal positions, some anywhere in the field
            if ($urandom_range(99) < 15)
                p = 8'($urandom_range(255));
            else if (f == ils_pkg::FUNC_ADD_AT || n == 0)
                p = 8'($urandom_range(n));
            else
                p = 8'($urandom_range(n - 1));
            issue(f, p, $urandom);
            if (f <= ils_pkg::FUNC_DELETE)
                counted++;
        end
        start = 1'b0;
    endtask

    initial
    begin
        sb = new;
        start = 1'b0;
        cmd = '0;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty list corner cases and unknown operations, then small-list inserts, reads and deletes
        issue(ils_pkg::FUNC_GET, 8'd0, 32'sd0);
        issue(ils_pkg::FUNC_DELETE, 8'd0, 32'sd0);
        issue(ils_pkg::FUNC_ADD_AT, 8'd1, 32'sd7);
        for (int f = ils_pkg::FUNC_DELETE + 1; f < 8; f++)
            issue(f[2:0], 8'hff, 32'sh7fffffff);
        issue(ils_pkg::FUNC_ADD_AT, 8'd0, 32'sh7fffffff);
        issue(ils_pkg::FUNC_ADD_HEAD, 8'd0, 32'sh80000000);
        issue(ils_pkg::FUNC_ADD_TAIL, 8'hff, -32'sd1);
        issue(ils_pkg::FUNC_ADD_AT, 8'd1, 32'sh55555555);
        for (int i = 0; i < 4; i++)
            issue(ils_pkg::FUNC_GET, i[7:0], 32'sd0);
        issue(ils_pkg::FUNC_GET, 8'd4, 32'sd0);
        issue(ils_pkg::FUNC_GET, 8'hff, 32'sd0);
        issue(ils_pkg::FUNC_DELETE, 8'hff, 32'sd0);
        issue(ils_pkg::FUNC_ADD_AT, 8'd5, 32'sd1);
        issue(ils_pkg::FUNC_DELETE, 8'd1, 32'sd0);
        issue(ils_pkg::FUNC_DELETE, 8'd2, 32'sd0);

        // fill up, then poke the full list
        while (sb.shadow_count < CAPACITY)
            issue(ils_pkg::FUNC_ADD_TAIL, 8'd0, $urandom);
        issue(ils_pkg::FUNC_ADD_HEAD, 8'd0, 32'sd1);
        issue(ils_pkg::FUNC_ADD_TAIL, 8'd0, 32'sd1);
        issue(ils_pkg::FUNC_ADD_AT, 8'(CAPACITY), 32'sd1);
        issue(ils_pkg::FUNC_ADD_AT, 8'(CAPACITY + 1), 32'sd1);
        issue(ils_pkg::FUNC_GET, 8'(CAPACITY - 1), 32'sd0);
        issue(ils_pkg::FUNC_DELETE, 8'(CAPACITY - 1), 32'sd0);
        issue(ils_pkg::FUNC_DELETE, 8'd0, 32'sd0);
        drain();

        run_phase(320, 9);
        drain();
        run_phase(310, 68);
        drain();
        run_phase(320, 0);
        drain();
        repeat (6) @(negedge clk);

        if (sb.pending_results.size() != 0)
            sb.report("commands left without a result");
        $display("covered %0d commands and %0d results, list depth up to %0d",
                 sb.n_commands, sb.n_results, sb.peak_count);
        $display("saw %0d list-full and %0d out-of-range responses",
                 sb.n_full, sb.n_range);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
